[rtl/packet_latency_jitter_loss_monitor_top_macros.svh]
// Assertion macros shared by the packet latency monitor RTL.
`ifndef PACKET_LATENCY_JITTER_LOSS_MONITOR_TOP_MACROS_SVH
`define PACKET_LATENCY_JITTER_LOSS_MONITOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Condition that must hold at every clock edge outside reset.
`define PLM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("plm assertion failed");
// Condition that must hold in the cycle after the trigger.
`define PLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plm assertion failed");
`else
`define PLM_ASSERT_ALWAYS(lbl, cond)
`define PLM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/plm_pkg.sv]
// Package with constants and types of the packet latency monitor.
`timescale 1ns / 1ps
package plm_pkg;

  localparam int TIME_WIDTH_DEF = 48;
  localparam logic [31:0] GAP_LIMIT_DEF = 32'd10000;
  localparam logic [31:0] REPORT_RST = 32'd1000;

  localparam int CNT_W = 48;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Divider lanes: dividend and divisor widths.
  localparam int NUM_W = 72;
  localparam int DEN_W = 64;
  localparam int LANES = 4;
  localparam int LANE_RATE = 0;
  localparam int LANE_MLAT = 1;
  localparam int LANE_MJIT = 2;
  localparam int LANE_LOSS = 3;

  localparam logic [17:0] RATE_SCALE = 18'd256000;
  localparam logic [14:0] LOSS_SCALE = 15'd25600;

  // Quotient caps, one per lane.
  localparam logic [LANES-1:0][NUM_W-1:0] LANE_CAP = {
    72'd25600,
    {15'd0, {57{1'b1}}},
    {16'd0, {56{1'b1}}},
    {32'd0, {40{1'b1}}}
  };

  localparam int QUEUE_DEPTH = 2;

  // One classified packet waiting for its divisions.
  typedef struct packed {
    logic signed [48:0] latency;
    logic [48:0] jitter;
    logic [47:0] received_count;
    logic [47:0] lost_count;
    logic signed [48:0] lowest_latency;
    logic [47:0] highest_latency;
    logic [48:0] highest_jitter;
    logic [31:0] sequence_num;
    logic mean_neg;
    logic jit_zero;
    logic rate_upd;
    logic [LANES-1:0][NUM_W-1:0] num;
    logic [LANES-1:0][DEN_W-1:0] den;
  } job_t;

endpackage

[rtl/plm_channels.sv]
// Valid/ready channel interfaces for packets in and snapshots out.
`timescale 1ns / 1ps
interface plm_in_if;
  logic valid;
  logic ready;
  logic [47:0] receive_time;
  logic [47:0] send_stamp;
  logic [31:0] sequence_req;
  modport source(output valid, receive_time, send_stamp, sequence_req, input ready);
  modport sink(input valid, receive_time, send_stamp, sequence_req, output ready);
endinterface

interface plm_out_if;
  logic valid;
  logic ready;
  logic signed [48:0] latency;
  logic [48:0] jitter;
  logic [47:0] received_count;
  logic [47:0] lost_count;
  logic signed [48:0] lowest_latency;
  logic [47:0] highest_latency;
  logic [48:0] highest_jitter;
  logic signed [56:0] mean_latency_q8;
  logic [56:0] mean_jitter_q8;
  logic [14:0] loss_percent_q8;
  logic [39:0] rate_q8;
  logic [31:0] previous_sequence;
  modport source(output valid, latency, jitter, received_count, lost_count,
                 lowest_latency, highest_latency, highest_jitter, mean_latency_q8,
                 mean_jitter_q8, loss_percent_q8, rate_q8, previous_sequence,
                 input ready);
  modport sink(input valid, latency, jitter, received_count, lost_count,
               lowest_latency, highest_latency, highest_jitter, mean_latency_q8,
               mean_jitter_q8, loss_percent_q8, rate_q8, previous_sequence,
               output ready);
endinterface

[rtl/packet_latency_jitter_loss_monitor_top.sv]
// Top level of the packet latency, jitter and loss monitor.
//
//   Channel    Dir   Handshake           Carries
//   in_ch      in    valid/ready         receive_time, send_stamp, sequence_req
//   out_ch     out   valid/ready         one statistics snapshot per packet
//   cfg        in    cfg_we/cfg_wdata    report_interval
//
// A snapshot becomes valid after its packet leaves the queue for the back end,
// passes the four parallel bit-serial dividers and loads the output register.
// The back end runs all 72 quotient bits of a job before it takes the next one.
// Synchronous reset clears all statistics; report_interval returns to 1000.
// A two-entry queue lets the front accept packets while dividers run; a held
// snapshot keeps the back end waiting, and the input stalls when the queue is full.
`timescale 1ns / 1ps
`include "packet_latency_jitter_loss_monitor_top_macros.svh"
module packet_latency_jitter_loss_monitor_top #(
  parameter int TIME_WIDTH = plm_pkg::TIME_WIDTH_DEF,
  parameter logic [31:0] GAP_LIMIT = plm_pkg::GAP_LIMIT_DEF
) (
  input  logic clk,
  input  logic rst,
  plm_in_if.sink in_ch,
  plm_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [31:0] cfg_wdata
);
  import plm_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH) + 1;

  job_t push_data, pop_data;
  logic q_push, q_pop, q_full, q_empty;
  logic [QCW-1:0] q_count;

  plm_front #(
    .TIME_WIDTH(TIME_WIDTH),
    .GAP_LIMIT(GAP_LIMIT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(push_data)
  );

  plm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .data_in(push_data),
    .pop(q_pop),
    .data_out(pop_data),
    .count(q_count),
    .full(q_full),
    .empty(q_empty)
  );

  plm_back u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_data(pop_data),
    .q_pop(q_pop),
    .out_ch(out_ch)
  );

  // Queue bookkeeping checks.
  `PLM_ASSERT_ALWAYS(a_queue_bound, q_count <= QCW'(QUEUE_DEPTH))
  `PLM_ASSERT_ALWAYS(a_no_overflow, !(q_push && q_full))
  `PLM_ASSERT_NEXT(a_push_fills, q_push, q_count != '0)

endmodule

[rtl/plm_front.sv]
// Front end: accepts packets, updates statistics and builds division jobs.
`timescale 1ns / 1ps
module plm_front #(
  parameter int TIME_WIDTH = plm_pkg::TIME_WIDTH_DEF,
  parameter logic [31:0] GAP_LIMIT = plm_pkg::GAP_LIMIT_DEF
) (
  input  logic clk,
  input  logic rst,
  plm_in_if.sink in_ch,
  input  logic cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic q_full,
  output logic q_push,
  output plm_pkg::job_t q_data
);
  import plm_pkg::*;

  logic [31:0] report_interval;
  logic signed [63:0] prior_latency;
  logic first_seen;
  logic signed [63:0] latency_total;
  logic [63:0] jitter_total;
  logic signed [63:0] min_latency;
  logic min_valid;
  logic signed [63:0] max_latency;
  logic [63:0] max_jitter;
  logic [47:0] rx_total;
  logic [47:0] lost_total;
  logic [31:0] last_sequence;
  logic [TIME_WIDTH-1:0] window_start;
  logic [47:0] window_count;

  logic [TIME_WIDTH-1:0] rt, st, lat_mag_t, elapsed, ws0;
  logic [63:0] mag64, lat_abs, jit, jt_next, lt_mag;
  logic signed [63:0] lat, lt_next, min_next, max_next;
  logic [64:0] diff, negd, jt_sum, lt_sum;
  logic [63:0] max_jit_next;
  logic [47:0] rx_next, lost_next, wc0, wc1;
  logic [48:0] lost_sum, loss_total;
  logic [31:0] expect_seq, gap, gap_add;
  logic fresh, roll;
  logic [65:0] rate_prod;
  logic [62:0] loss_prod;

  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && !q_full;

  // Latency, clamped to the signed 64-bit range.
  always_comb begin
    rt = TIME_WIDTH'(in_ch.receive_time);
    st = TIME_WIDTH'(in_ch.send_stamp);
    lat_mag_t = (rt >= st) ? rt - st : st - rt;
    mag64 = 64'(lat_mag_t);
    lat_abs = mag64[63] ? {1'b0, {63{1'b1}}} : mag64;
    lat = (rt >= st) ? $signed(lat_abs) : -$signed(lat_abs);
  end

  // Jitter and the saturating sums.
  always_comb begin
    diff = {lat[63], lat} - {prior_latency[63], prior_latency};
    negd = -diff;
    jit = first_seen ? '0 : (diff[64] ? negd[63:0] : diff[63:0]);
    jt_sum = {1'b0, jitter_total} + {1'b0, jit};
    jt_next = jt_sum[64] ? '1 : jt_sum[63:0];
    max_jit_next = (jit > max_jitter) ? jit : max_jitter;
    lt_sum = {latency_total[63], latency_total} + {lat[63], lat};
    if (lt_sum[64] != lt_sum[63]) begin
      lt_next = lt_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      lt_next = $signed(lt_sum[63:0]);
    end
    lt_mag = lt_next[63] ? 64'(-lt_next) : 64'(lt_next);
    min_next = (!min_valid || lat < min_latency) ? lat : min_latency;
    max_next = (lat > max_latency) ? lat : max_latency;
    rx_next = (rx_total == COUNT_MAX) ? rx_total : rx_total + 48'd1;
  end

  // Loss from sequence gaps; all ones means no previous packet.
  always_comb begin
    expect_seq = last_sequence + 32'd1;
    gap = in_ch.sequence_req - expect_seq;
    gap_add = (last_sequence != '1 && gap < GAP_LIMIT) ? gap : '0;
    lost_sum = {1'b0, lost_total} + 49'(gap_add);
    lost_next = (lost_sum > 49'(COUNT_MAX)) ? COUNT_MAX : lost_sum[47:0];
    loss_total = 49'(rx_next) + 49'(lost_next);
  end

  // Rate window.
  always_comb begin
    fresh = (window_start == '0);
    ws0 = fresh ? rt : window_start;
    wc0 = fresh ? '0 : window_count;
    wc1 = (wc0 == COUNT_MAX) ? wc0 : wc0 + 48'd1;
    elapsed = rt - ws0;
    roll = 64'(elapsed) >= 64'(report_interval);
    rate_prod = 66'(wc1) * 66'(RATE_SCALE);
    loss_prod = 63'(lost_next) * 63'(LOSS_SCALE);
  end

  // Job for the back end.
  always_comb begin
    q_data.latency = lat[48:0];
    q_data.jitter = jit[48:0];
    q_data.received_count = rx_next;
    q_data.lost_count = lost_next;
    q_data.lowest_latency = min_next[48:0];
    q_data.highest_latency = max_next[47:0];
    q_data.highest_jitter = max_jit_next[48:0];
    q_data.sequence_num = in_ch.sequence_req;
    q_data.mean_neg = lt_next[63];
    q_data.jit_zero = (rx_next < 48'd2);
    q_data.rate_upd = roll;
    q_data.num[LANE_RATE] = NUM_W'(rate_prod);
    q_data.den[LANE_RATE] = 64'(elapsed);
    q_data.num[LANE_MLAT] = {lt_mag, 8'd0};
    q_data.den[LANE_MLAT] = 64'(rx_next);
    q_data.num[LANE_MJIT] = {jt_next, 8'd0};
    q_data.den[LANE_MJIT] = 64'(rx_next - 48'd1);
    q_data.num[LANE_LOSS] = NUM_W'(loss_prod);
    q_data.den[LANE_LOSS] = 64'(loss_total);
  end

  // State update on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      report_interval <= REPORT_RST;
      prior_latency <= '0;
      first_seen <= 1'b1;
      latency_total <= '0;
      jitter_total <= '0;
      min_latency <= '0;
      min_valid <= 1'b0;
      max_latency <= '0;
      max_jitter <= '0;
      rx_total <= '0;
      lost_total <= '0;
      last_sequence <= '1;
      window_start <= '0;
      window_count <= '0;
    end else begin
      if (cfg_we) begin
        report_interval <= cfg_wdata;
      end
      if (q_push) begin
        prior_latency <= lat;
        first_seen <= 1'b0;
        latency_total <= lt_next;
        jitter_total <= jt_next;
        min_latency <= min_next;
        min_valid <= 1'b1;
        max_latency <= max_next;
        max_jitter <= max_jit_next;
        rx_total <= rx_next;
        lost_total <= lost_next;
        last_sequence <= in_ch.sequence_req;
        window_start <= roll ? rt : ws0;
        window_count <= roll ? '0 : wc1;
      end
    end
  end

endmodule

[rtl/plm_queue.sv]
// Short job queue between front and back end.
`timescale 1ns / 1ps
module plm_queue #(
  parameter int DEPTH = plm_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  plm_pkg::job_t data_in,
  input  logic pop,
  output plm_pkg::job_t data_out,
  output logic [$clog2(DEPTH):0] count,
  output logic full,
  output logic empty
);
  import plm_pkg::*;

  localparam int PW = $clog2(DEPTH);

  job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;

  assign full = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign data_out = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= data_in;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

[rtl/plm_divider.sv]
// Restoring divider, one quotient bit per cycle while step is high, with a capped result.
`timescale 1ns / 1ps
module plm_divider (
  input  logic clk,
  input  logic start,
  input  logic step,
  input  logic [plm_pkg::NUM_W-1:0] num,
  input  logic [plm_pkg::DEN_W-1:0] den,
  input  logic [plm_pkg::NUM_W-1:0] cap,
  output logic [plm_pkg::NUM_W-1:0] quot
);
  import plm_pkg::*;

  logic [DEN_W-1:0] divisor, rem;
  logic [NUM_W-1:0] dq;
  logic [DEN_W:0] r_sh, r_sub;
  logic take;

  // Trial subtraction for the next quotient bit.
  always_comb begin
    r_sh = {rem, dq[NUM_W-1]};
    r_sub = r_sh - {1'b0, divisor};
    take = (r_sh >= {1'b0, divisor});
    quot = (dq > cap) ? cap : dq;
  end

  // Dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= den;
      rem <= '0;
      dq <= num;
    end else if (step) begin
      rem <= take ? r_sub[DEN_W-1:0] : r_sh[DEN_W-1:0];
      dq <= {dq[NUM_W-2:0], take};
    end
  end

endmodule

[rtl/plm_back.sv]
// Back end: runs the divisions of one job and holds the snapshot output.
`timescale 1ns / 1ps
module plm_back (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  plm_pkg::job_t q_data,
  output logic q_pop,
  plm_out_if.source out_ch
);
  import plm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam int SW = $clog2(NUM_W);

  logic [1:0] state, state_next;
  logic [SW-1:0] step_cnt;
  job_t job;
  logic [39:0] rate_reg, rate_next;
  logic [LANES-1:0][NUM_W-1:0] quot;
  logic load_out;
  logic [56:0] mlat_mag;

  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign load_out = (state == ST_DONE) && (!out_ch.valid || out_ch.ready);

  // Division lanes.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    plm_divider u_div (
      .clk(clk),
      .start(q_pop),
      .step(state == ST_RUN),
      .num(q_data.num[i]),
      .den(q_data.den[i]),
      .cap(LANE_CAP[i]),
      .quot(quot[i])
    );
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_pop) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (step_cnt == SW'(NUM_W-1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    rate_next = job.rate_upd ? quot[LANE_RATE][39:0] : rate_reg;
    mlat_mag = quot[LANE_MLAT][56:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step_cnt <= '0;
      rate_reg <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        step_cnt <= '0;
      end else if (state == ST_RUN) begin
        step_cnt <= step_cnt + SW'(1);
      end
      if (load_out) begin
        rate_reg <= rate_next;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // Job and snapshot payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_data;
    end
    if (load_out) begin
      out_ch.latency <= job.latency;
      out_ch.jitter <= job.jitter;
      out_ch.received_count <= job.received_count;
      out_ch.lost_count <= job.lost_count;
      out_ch.lowest_latency <= job.lowest_latency;
      out_ch.highest_latency <= job.highest_latency;
      out_ch.highest_jitter <= job.highest_jitter;
      out_ch.mean_latency_q8 <= job.mean_neg ? -$signed(mlat_mag) : $signed(mlat_mag);
      out_ch.mean_jitter_q8 <= job.jit_zero ? '0 : quot[LANE_MJIT][56:0];
      out_ch.loss_percent_q8 <= quot[LANE_LOSS][14:0];
      out_ch.rate_q8 <= rate_next;
      out_ch.previous_sequence <= job.sequence_num;
    end
  end

endmodule
